FILE: hdl/tpc_pkg.sv
// ---------------------------------------------------------------------------
// Tausworthe pattern checker package
// Shared types, operation codes, reset seeds and the generator step function.
// ---------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

    localparam int COUNT_WIDTH = 40;
    localparam int INDEX_WIDTH = 40;
    localparam int WORD_WIDTH  = 32;
    localparam int OP_WIDTH    = 2;
    localparam int CFG_IDX_W   = 2;

    // Operation codes
    localparam logic [OP_WIDTH-1:0] OP_RESTART  = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_GENERATE = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_VERIFY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_THREE = 2'd2;

    localparam logic [WORD_WIDTH-1:0] SEED_ONE_RESET   = 32'd1;
    localparam logic [WORD_WIDTH-1:0] SEED_TWO_RESET   = 32'd200;
    localparam logic [WORD_WIDTH-1:0] SEED_THREE_RESET = 32'd300;

    // Step constants of the three components
    localparam logic [WORD_WIDTH-1:0] MASK_ONE   = 32'hFFFF_FFFE;
    localparam logic [WORD_WIDTH-1:0] MASK_TWO   = 32'hFFFF_FFF8;
    localparam logic [WORD_WIDTH-1:0] MASK_THREE = 32'hFFFF_FFF0;

    typedef struct packed {
        logic [OP_WIDTH-1:0]   op;
        logic [WORD_WIDTH-1:0] read_word;
    } req_item_t;

    typedef struct packed {
        logic [WORD_WIDTH-1:0]  pattern_word;
        logic                   mismatch;
        logic                   error_seen;
        logic [INDEX_WIDTH-1:0] first_error_index;
    } rsp_item_t;

    typedef struct packed {
        logic restart;
        logic advance;
    } step_ctrl_t;

    // One component step: ((s & c) << d) ^ (((s << a) ^ s) >> b), logical shifts.
    function automatic logic [WORD_WIDTH-1:0] taus_step(
        input logic [WORD_WIDTH-1:0] s,
        input int unsigned           a,
        input int unsigned           b,
        input logic [WORD_WIDTH-1:0] c,
        input int unsigned           d
    );
        logic [WORD_WIDTH-1:0] left;
        logic [WORD_WIDTH-1:0] right;
        left  = (s & c) << d;
        right = ((s << a) ^ s) >> b;
        return left ^ right;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tpc_gen.sv
// ---------------------------------------------------------------------------
// Tausworthe pattern checker generator
// Holds the three generator words; reloads them from the seeds or steps them.
// ---------------------------------------------------------------------------
`default_nettype none

module tpc_gen (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tpc_pkg::step_ctrl_t            ctrl,
    input  wire logic [tpc_pkg::WORD_WIDTH-1:0] seed_one,
    input  wire logic [tpc_pkg::WORD_WIDTH-1:0] seed_two,
    input  wire logic [tpc_pkg::WORD_WIDTH-1:0] seed_three,
    output logic      [tpc_pkg::WORD_WIDTH-1:0] word
);
    import tpc_pkg::*;

    logic [WORD_WIDTH-1:0] gen_one_reg;
    logic [WORD_WIDTH-1:0] gen_two_reg;
    logic [WORD_WIDTH-1:0] gen_three_reg;
    logic [WORD_WIDTH-1:0] gen_one_next;
    logic [WORD_WIDTH-1:0] gen_two_next;
    logic [WORD_WIDTH-1:0] gen_three_next;

    always_comb
    begin
        gen_one_next   = taus_step(gen_one_reg, 13, 19, MASK_ONE, 12);
        gen_two_next   = taus_step(gen_two_reg, 2, 25, MASK_TWO, 4);
        gen_three_next = taus_step(gen_three_reg, 3, 11, MASK_THREE, 17);
    end

    assign word = gen_one_next ^ gen_two_next ^ gen_three_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_one_reg   <= SEED_ONE_RESET;
            gen_two_reg   <= SEED_TWO_RESET;
            gen_three_reg <= SEED_THREE_RESET;
        end
        else if (ctrl.restart)
        begin
            gen_one_reg   <= seed_one;
            gen_two_reg   <= seed_two;
            gen_three_reg <= seed_three;
        end
        else if (ctrl.advance)
        begin
            gen_one_reg   <= gen_one_next;
            gen_two_reg   <= gen_two_next;
            gen_three_reg <= gen_three_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tpc_record.sv
// ---------------------------------------------------------------------------
// Tausworthe pattern checker error record
// Word counter, sticky error flag and index of the first mismatch.
// ---------------------------------------------------------------------------
`default_nettype none

module tpc_record (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tpc_pkg::step_ctrl_t             ctrl,
    input  wire logic                            mismatch,
    output logic                                 error_seen,
    output logic      [tpc_pkg::INDEX_WIDTH-1:0] first_error_index
);
    import tpc_pkg::*;

    logic [COUNT_WIDTH-1:0] word_cnt_reg;
    logic [COUNT_WIDTH-1:0] word_cnt_next;
    logic                   error_flag_reg;
    logic                   error_flag_next;
    logic [COUNT_WIDTH-1:0] first_err_pos_reg;
    logic [COUNT_WIDTH-1:0] first_err_pos_next;

    always_comb
    begin
        word_cnt_next      = word_cnt_reg;
        error_flag_next    = error_flag_reg;
        first_err_pos_next = first_err_pos_reg;
        if (ctrl.restart)
        begin
            word_cnt_next      = '0;
            error_flag_next    = 1'b0;
            first_err_pos_next = '0;
        end
        else if (ctrl.advance)
        begin
            word_cnt_next = word_cnt_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            // Only the first mismatch since restart is recorded.
            if (mismatch && !error_flag_reg)
            begin
                error_flag_next    = 1'b1;
                first_err_pos_next = word_cnt_reg;
            end
        end
    end

    // The result shows the record after this transaction is applied.
    assign error_seen        = error_flag_next;
    assign first_error_index = error_flag_next ? INDEX_WIDTH'(first_err_pos_next) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_cnt_reg      <= '0;
            error_flag_reg    <= 1'b0;
            first_err_pos_reg <= '0;
        end
        else
        begin
            word_cnt_reg      <= word_cnt_next;
            error_flag_reg    <= error_flag_next;
            first_err_pos_reg <= first_err_pos_next;
        end
    end

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.restart |=> (!error_flag_reg && word_cnt_reg == '0))
        else $error("restart did not clear the error record");

    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (error_flag_reg && !ctrl.restart) |=> error_flag_reg)
        else $error("error flag dropped without restart");

    a_first_pos_held: assert property (@(posedge clk) disable iff (!rst_n)
        (error_flag_reg && !ctrl.restart) |=> $stable(first_err_pos_reg))
        else $error("first error index changed after it was recorded");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.restart && !ctrl.advance) |=> $stable(word_cnt_reg))
        else $error("word counter moved without a transaction");

endmodule

`default_nettype wire

FILE: hdl/tausworthe_pattern_checker_unit.sv
// ---------------------------------------------------------------------------
// Tausworthe pattern checker unit
// Generates taus88 pattern words and checks words read back from storage.
//
//   Channel  Direction  Handshake                  Payload
//   req      in         req_valid / req_ready      req_item_t (op, read_word)
//   rsp      out        rsp_valid / rsp_ready      rsp_item_t
//   cfg      in         cfg_write_en               cfg_index, cfg_wdata
//
// A transaction is taken into the request register, processed against the
// generator and error record once the result register can take it, and lands
// in the result register. One transaction per cycle is sustained while
// rsp_ready is held high.
// Reset loads the seeds with 1, 200 and 300 and the generator from them.
// A stalled result register holds the request stage; ready chains backward.
// ---------------------------------------------------------------------------
`default_nettype none

module tausworthe_pattern_checker_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire tpc_pkg::req_item_t            req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output tpc_pkg::rsp_item_t                 rsp,
    input  wire logic                          cfg_write_en,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tpc_pkg::WORD_WIDTH-1:0] cfg_wdata
);
    import tpc_pkg::*;

    logic                   req_valid_reg;
    req_item_t              req_item_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    rsp_item_t              rsp_item_reg;
    rsp_item_t              rsp_item_next;
    logic [WORD_WIDTH-1:0]  seed_one_reg;
    logic [WORD_WIDTH-1:0]  seed_two_reg;
    logic [WORD_WIDTH-1:0]  seed_three_reg;
    logic                   advance;
    step_ctrl_t             ctrl;
    logic [WORD_WIDTH-1:0]  gen_word;
    logic                   word_miss;
    logic                   error_seen;
    logic [INDEX_WIDTH-1:0] first_error_index;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;

    always_comb
    begin
        ctrl.restart = advance && (req_item_reg.op == OP_RESTART);
        ctrl.advance = advance && ((req_item_reg.op == OP_GENERATE) ||
                                   (req_item_reg.op == OP_VERIFY));
    end

    assign word_miss = (req_item_reg.op == OP_VERIFY) && (req_item_reg.read_word != gen_word);

    tpc_gen u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .seed_one   (seed_one_reg),
        .seed_two   (seed_two_reg),
        .seed_three (seed_three_reg),
        .word       (gen_word)
    );

    tpc_record u_record (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .mismatch          (word_miss),
        .error_seen        (error_seen),
        .first_error_index (first_error_index)
    );

    always_comb
    begin
        rsp_item_next.pattern_word      = ctrl.advance ? gen_word : '0;
        rsp_item_next.mismatch          = ctrl.advance && word_miss;
        rsp_item_next.error_seen        = error_seen;
        rsp_item_next.first_error_index = first_error_index;
        rsp_valid_next                  = advance || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_item_reg <= req;
        end
        if (advance)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_one_reg   <= SEED_ONE_RESET;
            seed_two_reg   <= SEED_TWO_RESET;
            seed_three_reg <= SEED_THREE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_SEED_ONE:   seed_one_reg   <= cfg_wdata;
                REG_SEED_TWO:   seed_two_reg   <= cfg_wdata;
                REG_SEED_THREE: seed_three_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

    a_miss_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (!rsp_item_reg.mismatch || rsp_item_reg.error_seen))
        else $error("mismatch reported without the error flag");

    a_stall_holds_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !advance) |=> (req_valid_reg && $stable(req_item_reg)))
        else $error("request register changed while stalled");

    a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("processed transaction produced no result");

endmodule

`default_nettype wire
